[rtl/edav_pkg.sv]
`default_nettype none
package edav_pkg;

  localparam int ECHO_W  = 16;
  localparam int DIST_W  = 19;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 8;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  // Distance in 1/256 cm is (echo_us * 1114) >> 8.
  localparam logic [10:0] ECHO_SCALE = 11'd1114;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_MIN_DIST   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_MAX_DIST   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_SAMPLE_CNT = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_WALL_THR   = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_VOTE_TOTAL = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_VOTE_MIN   = 3'd7;

  localparam logic        RST_MODE       = 1'b0;
  localparam logic [15:0] RST_TIMEOUT    = 16'd3000;
  localparam logic [15:0] RST_MIN_DIST   = 16'd512;
  localparam logic [15:0] RST_MAX_DIST   = 16'd13056;
  localparam logic [7:0]  RST_SAMPLE_CNT = 8'd5;
  localparam logic [15:0] RST_WALL_THR   = 16'd5120;
  localparam logic [7:0]  RST_VOTE_TOTAL = 8'd5;
  localparam logic [7:0]  RST_VOTE_MIN   = 8'd3;

  localparam logic MODE_AVERAGE = 1'b0;
  localparam logic MODE_VOTE    = 1'b1;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] timeout_us;
    logic [15:0] min_dist;
    logic [15:0] max_dist;
    logic [7:0]  sample_count;
    logic [15:0] wall_threshold;
    logic [7:0]  vote_total;
    logic [7:0]  vote_minimum;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  // cb is the carry out of an add or the borrow out of a subtract.
  typedef struct packed {
    logic [SUM_W-1:0] y;
    logic             cb;
  } alu_rsp_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        distance_valid;
    logic        wall_ahead;
    logic [7:0]  detections;
  } res_t;

endpackage
`default_nettype wire

[rtl/echo_distance_average_and_vote.sv]
// Echo range filter: turns ultrasonic echo widths into distances and either
// averages them over a run or votes on whether a wall is near.
// Input channel: in_valid/in_stall with echo_us. The block stalls the input
// while it works on an item, so one item is in flight at a time.
// Output channel: out_valid/out_stall with distance, distance_valid,
// wall_ahead and detections. One item comes out at the end of each run.
// For each item the block multiplies by the scale factor, then runs the limit
// tests and accumulation on a single shared add/subtract unit, before it can
// take the next one. An item that ends a run adds a result state, from which
// the result moves to the output register. Ending an average run with valid
// samples first adds restoring division on the same unit. The result sits in
// an output register; the block keeps working while it waits there, and only
// holds its next result when that register is still stalled.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, to be written
// only while idle; the block itself does not enforce this. Writing the mode register restarts the run.
// Reset (rst, synchronous) restores the register defaults and clears the run.
`default_nettype none
module echo_distance_average_and_vote (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [15:0]                     echo_us,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [15:0]                    distance,
  output logic                           distance_valid,
  output logic                           wall_ahead,
  output logic [7:0]                     detections,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [edav_pkg::CIDX_W-1:0]     cfg_index,
  input  wire [edav_pkg::CDATA_W-1:0]    cfg_data
);
  import edav_pkg::*;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  res_t     res;
  logic     res_valid;
  logic     res_take;
  logic     cfg_write;
  logic     clear_run;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign clear_run = cfg_write && (cfg_index == CFG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= RST_MODE;
      cfg.timeout_us     <= RST_TIMEOUT;
      cfg.min_dist       <= RST_MIN_DIST;
      cfg.max_dist       <= RST_MAX_DIST;
      cfg.sample_count   <= RST_SAMPLE_CNT;
      cfg.wall_threshold <= RST_WALL_THR;
      cfg.vote_total     <= RST_VOTE_TOTAL;
      cfg.vote_minimum   <= RST_VOTE_MIN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MODE:       cfg.mode           <= cfg_data[0];
        CFG_TIMEOUT:    cfg.timeout_us     <= cfg_data;
        CFG_MIN_DIST:   cfg.min_dist       <= cfg_data;
        CFG_MAX_DIST:   cfg.max_dist       <= cfg_data;
        CFG_SAMPLE_CNT: cfg.sample_count   <= cfg_data[7:0];
        CFG_WALL_THR:   cfg.wall_threshold <= cfg_data;
        CFG_VOTE_TOTAL: cfg.vote_total     <= cfg_data[7:0];
        CFG_VOTE_MIN:   cfg.vote_minimum   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  edav_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  edav_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clear_run (clear_run),
    .in_valid  (in_valid),
    .echo_us   (echo_us),
    .in_stall  (in_stall),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      distance       <= res.distance;
      distance_valid <= res.distance_valid;
      wall_ahead     <= res.wall_ahead;
      detections     <= res.detections;
    end
  end

`ifndef ASSERT_OFF
  a_avg_fields_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && distance_valid |-> !wall_ahead && detections == 8'd0)
    else $error("average result carries vote fields");

  a_no_mean_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !distance_valid |-> distance == 16'd0)
    else $error("result without valid samples has nonzero distance");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in progress");
`endif

endmodule
`default_nettype wire

[rtl/edav_alu.sv]
`default_nettype none
module edav_alu (
  input  var edav_pkg::alu_req_t req,
  output var edav_pkg::alu_rsp_t rsp
);
  import edav_pkg::*;

  logic [SUM_W:0] full;

  always_comb begin
    case (req.op)
      ALU_ADD: full = {1'b0, req.a} + {1'b0, req.b};
      default: full = {1'b0, req.a} - {1'b0, req.b};
    endcase
  end

  assign rsp.y  = full[SUM_W-1:0];
  assign rsp.cb = full[SUM_W];

endmodule
`default_nettype wire

[rtl/edav_ctrl.sv]
`default_nettype none
module edav_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  var edav_pkg::cfg_t     cfg,
  input  wire                    clear_run,
  input  wire                    in_valid,
  input  wire [15:0]             echo_us,
  output logic                   in_stall,
  output edav_pkg::alu_req_t     alu_req,
  input  var edav_pkg::alu_rsp_t alu_rsp,
  output logic                   res_valid,
  input  wire                    res_take,
  output edav_pkg::res_t         res
);
  import edav_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_TO    = 4'd2;
  localparam logic [3:0] S_MIN   = 4'd3;
  localparam logic [3:0] S_MAX   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_LIMIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state;
  logic [ECHO_W-1:0] echo;
  logic [DIST_W-1:0] sample_dist;
  logic              sample_ok;
  logic [SUM_W-1:0]  distance_sum;
  logic [CNT_W-1:0]  valid_samples;
  logic [CNT_W-1:0]  samples_seen;
  logic [CNT_W-1:0]  near_count;
  logic [CNT_W-1:0]  div_rem;
  logic [SUM_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_den;
  logic [4:0]        div_cnt;

  logic [26:0]       product;
  logic [CNT_W:0]    div_shift;
  logic [CNT_W-1:0]  run_limit;

  assign product   = 27'(echo) * 27'(ECHO_SCALE);
  assign div_shift = {div_rem, div_quo[SUM_W-1]};
  assign run_limit = (cfg.mode == MODE_VOTE) ? cfg.vote_total : cfg.sample_count;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      S_TO: begin
        alu_req.a = SUM_W'(cfg.timeout_us);
        alu_req.b = SUM_W'(echo);
      end
      S_MIN: begin
        alu_req.a = SUM_W'(sample_dist);
        alu_req.b = SUM_W'(cfg.min_dist);
      end
      S_MAX: begin
        alu_req.a = SUM_W'(cfg.max_dist);
        alu_req.b = SUM_W'(sample_dist);
      end
      S_ACC: begin
        if (cfg.mode == MODE_VOTE) begin
          alu_req.a = SUM_W'(sample_dist);
          alu_req.b = SUM_W'(cfg.wall_threshold);
        end else begin
          alu_req.op = ALU_ADD;
          alu_req.a  = distance_sum;
          alu_req.b  = SUM_W'(sample_dist);
        end
      end
      S_LIMIT: begin
        alu_req.a = SUM_W'(samples_seen);
        alu_req.b = SUM_W'(run_limit);
      end
      S_DIV: begin
        alu_req.a = SUM_W'(div_shift);
        alu_req.b = SUM_W'(div_den);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_ok     <= 1'b0;
      distance_sum  <= '0;
      valid_samples <= '0;
      samples_seen  <= '0;
      near_count    <= '0;
      div_cnt       <= '0;
    end else begin
      unique case (state) inside
        S_IDLE: begin
          if (in_valid) begin
            echo  <= echo_us;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          sample_dist <= product[26:8];
          sample_ok   <= (echo != '0);
          state       <= S_TO;
        end
        S_TO, S_MIN, S_MAX: begin
          // Each limit test passes when the subtract does not borrow.
          sample_ok <= sample_ok & ~alu_rsp.cb;
          state     <= (state == S_TO) ? S_MIN : (state == S_MIN) ? S_MAX : S_ACC;
        end
        S_ACC: begin
          samples_seen <= samples_seen + 1'b1;
          if (cfg.mode == MODE_VOTE) begin
            if (sample_ok && alu_rsp.cb) begin
              near_count <= near_count + 1'b1;
            end
          end else if (sample_ok) begin
            distance_sum  <= alu_rsp.y;
            valid_samples <= valid_samples + 1'b1;
          end
          state <= S_LIMIT;
        end
        S_LIMIT: begin
          if (alu_rsp.cb) begin
            state <= S_IDLE;
          end else begin
            distance_sum  <= '0;
            valid_samples <= '0;
            samples_seen  <= '0;
            near_count    <= '0;
            if (cfg.mode == MODE_VOTE) begin
              res.distance       <= '0;
              res.distance_valid <= 1'b0;
              res.wall_ahead     <= (near_count >= cfg.vote_minimum);
              res.detections     <= near_count;
              state              <= S_DONE;
            end else if (valid_samples == '0) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              div_quo <= distance_sum;
              div_rem <= '0;
              div_den <= valid_samples;
              div_cnt <= 5'(SUM_W - 1);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          div_rem <= alu_rsp.cb ? div_shift[CNT_W-1:0] : alu_rsp.y[CNT_W-1:0];
          div_quo <= {div_quo[SUM_W-2:0], ~alu_rsp.cb};
          if (div_cnt == '0) begin
            res.distance       <= {div_quo[14:0], ~alu_rsp.cb};
            res.distance_valid <= 1'b1;
            res.wall_ahead     <= 1'b0;
            res.detections     <= '0;
            state              <= S_DONE;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (clear_run) begin
        distance_sum  <= '0;
        valid_samples <= '0;
        samples_seen  <= '0;
        near_count    <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import edav_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int STUCK_LIMIT    = 2000;
  localparam int RAND_PHASES    = 15;
  localparam int PHASE_ITEMS    = 95;
  localparam int PRESSURE_PHASE = 2;
  localparam int CALM_PHASES    = 2;

  typedef enum logic {ROW_WRITE, ROW_ECHO} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CIDX_W-1:0] idx;
    logic [15:0]       val;
    logic              chk;
    res_t              want;
  } stim_row_t;

  localparam int DIR_ROWS = 40;

  // Echo rows carry the echo width in val; chk marks a result typed in by hand.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_ECHO,  '0,             16'd0,             1'b0, '0},
    '{ROW_ECHO,  '0,             16'd3001,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd65535,         1'b0, '0},
    '{ROW_ECHO,  '0,             16'd117,           1'b0, '0},
    '{ROW_ECHO,  '0,             16'd0,             1'b1, '{16'd0, 1'b0, 1'b0, 8'd0}},
    '{ROW_ECHO,  '0,             16'd3000,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd3000,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd3000,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd3000,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd3000,          1'b1, '{16'd13054, 1'b1, 1'b0, 8'd0}},
    '{ROW_ECHO,  '0,             16'd118,           1'b0, '0},
    '{ROW_ECHO,  '0,             16'd1,             1'b0, '0},
    '{ROW_ECHO,  '0,             16'd2999,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd1000,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd500,           1'b0, '0},
    '{ROW_WRITE, CFG_MODE,       16'(MODE_VOTE),    1'b0, '0},
    '{ROW_ECHO,  '0,             16'd1176,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd1176,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd1176,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd1177,          1'b0, '0},
    '{ROW_ECHO,  '0,             16'd0,             1'b0, '0},
    '{ROW_WRITE, CFG_VOTE_MIN,   16'd0,             1'b0, '0},
    '{ROW_WRITE, CFG_VOTE_TOTAL, 16'd0,             1'b0, '0},
    '{ROW_ECHO,  '0,             16'd0,             1'b1, '{16'd0, 1'b0, 1'b1, 8'd0}},
    '{ROW_WRITE, CFG_VOTE_MIN,   16'd255,           1'b0, '0},
    '{ROW_WRITE, CFG_WALL_THR,   16'd65535,         1'b0, '0},
    '{ROW_WRITE, CFG_VOTE_TOTAL, 16'd1,             1'b0, '0},
    '{ROW_ECHO,  '0,             16'd3000,          1'b0, '0},
    '{ROW_WRITE, CFG_MODE,       16'(MODE_AVERAGE), 1'b0, '0},
    '{ROW_WRITE, CFG_SAMPLE_CNT, 16'd0,             1'b0, '0},
    '{ROW_WRITE, CFG_MIN_DIST,   16'd0,             1'b0, '0},
    '{ROW_WRITE, CFG_MAX_DIST,   16'd65535,         1'b0, '0},
    '{ROW_WRITE, CFG_TIMEOUT,    16'd65535,         1'b0, '0},
    '{ROW_ECHO,  '0,             16'd65535,         1'b1, '{16'd0, 1'b0, 1'b0, 8'd0}},
    '{ROW_ECHO,  '0,             16'd1,             1'b1, '{16'd4, 1'b1, 1'b0, 8'd0}},
    '{ROW_WRITE, CFG_SAMPLE_CNT, 16'd4,             1'b0, '0},
    '{ROW_ECHO,  '0,             16'd500,           1'b0, '0},
    '{ROW_ECHO,  '0,             16'd600,           1'b0, '0},
    '{ROW_WRITE, CFG_SAMPLE_CNT, 16'd1,             1'b0, '0},
    '{ROW_ECHO,  '0,             16'd700,           1'b0, '0}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [15:0]       echo_us;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       distance;
  logic              distance_valid;
  logic              wall_ahead;
  logic [7:0]        detections;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [15:0]       cfg_data;

  // Copy of the register file and of the run in progress.
  cfg_t        model_cfg;
  logic [23:0] run_sum;
  logic [7:0]  run_hits;
  logic [7:0]  run_seen;
  logic [7:0]  run_near;

  res_t expected_results[$];
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  int   hold_asks    = 0;
  int   holds_served = 0;
  bit   tx_gaps      = 1'b1;
  bit   rx_stalls    = 1'b1;

  echo_distance_average_and_vote DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .echo_us        (echo_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .distance       (distance),
    .distance_valid (distance_valid),
    .wall_ahead     (wall_ahead),
    .detections     (detections),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Steps the run by one echo; returns 1 when the echo closes the run.
  function automatic bit filter_echo(input logic [15:0] echo, output res_t r);
    logic [26:0] prod;
    logic [18:0] sample_dist;
    logic [7:0]  run_len;
    bit          ok;
    prod = 27'(echo) * 27'(ECHO_SCALE);
    sample_dist = prod[26:8];
    ok = echo != 16'd0 && echo <= model_cfg.timeout_us &&
         sample_dist >= 19'(model_cfg.min_dist) &&
         sample_dist <= 19'(model_cfg.max_dist);
    r = '0;
    run_seen = run_seen + 8'd1;
    if (model_cfg.mode == MODE_AVERAGE) begin
      if (ok) begin
        run_sum  = run_sum + 24'(sample_dist);
        run_hits = run_hits + 8'd1;
      end
      run_len = model_cfg.sample_count;
    end else begin
      if (ok && sample_dist < 19'(model_cfg.wall_threshold))
        run_near = run_near + 8'd1;
      run_len = model_cfg.vote_total;
    end
    // A run length of zero behaves as one, since run_seen is at least one here.
    if (run_seen < run_len)
      return 1'b0;
    if (model_cfg.mode == MODE_AVERAGE) begin
      if (run_hits != 8'd0)
        r.distance = 16'(run_sum / 24'(run_hits));
      r.distance_valid = run_hits != 8'd0;
    end else begin
      r.wall_ahead = run_near >= model_cfg.vote_minimum;
      r.detections = run_near;
    end
    {run_sum, run_hits, run_seen, run_near} = '0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(input logic [CIDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_MODE: begin
        model_cfg.mode = data[0];
        {run_sum, run_hits, run_seen, run_near} = '0;
      end
      CFG_TIMEOUT:    model_cfg.timeout_us     = data;
      CFG_MIN_DIST:   model_cfg.min_dist       = data;
      CFG_MAX_DIST:   model_cfg.max_dist       = data;
      CFG_SAMPLE_CNT: model_cfg.sample_count   = data[7:0];
      CFG_WALL_THR:   model_cfg.wall_threshold = data;
      CFG_VOTE_TOTAL: model_cfg.vote_total     = data[7:0];
      CFG_VOTE_MIN:   model_cfg.vote_minimum   = data[7:0];
      default: ;
    endcase
  endfunction

  // Mostly a value from the given span, now and then one of the two 16-bit extremes.
  function automatic logic [15:0] pick_span(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0)
      return 16'h0000;
    if (roll == 1)
      return 16'hFFFF;
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [15:0] pick_echo();
    logic [15:0] top;
    int unsigned roll;
    top  = (model_cfg.timeout_us == 16'd0) ? 16'd1 : model_cfg.timeout_us;
    roll = $urandom_range(0, 19);
    if (roll < 2)
      return 16'd0;
    if (roll < 4)
      return 16'($urandom);
    if (roll == 4)
      return (top == 16'hFFFF) ? top : top + 16'd1;
    return 16'($urandom_range(1, top));
  endfunction

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_echo(input logic [15:0] echo, input bit use_typed, input res_t typed);
    res_t r;
    bit   closes;
    @(negedge clk);
    in_valid = 1'b1;
    echo_us  = echo;
    do @(posedge clk); while (in_stall !== 1'b0);
    closes = filter_echo(echo, r);
    if (use_typed)
      expected_results.push_back(typed);
    else if (closes)
      expected_results.push_back(r);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  // Lets every result drain, then gives an item that closes no run time to finish.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reshuffle_regs();
    if ($urandom_range(0, 1)) write_reg(CFG_MODE, 16'($urandom));
    if ($urandom_range(0, 1)) write_reg(CFG_TIMEOUT, pick_span(500, 20000));
    if ($urandom_range(0, 1)) write_reg(CFG_MIN_DIST, pick_span(0, 3000));
    if ($urandom_range(0, 1)) write_reg(CFG_MAX_DIST, pick_span(6000, 65535));
    if ($urandom_range(0, 1))
      write_reg(CFG_SAMPLE_CNT, {8'($urandom), 8'(pick_span(1, 8))});
    if ($urandom_range(0, 1)) write_reg(CFG_WALL_THR, pick_span(1000, 40000));
    if ($urandom_range(0, 1))
      write_reg(CFG_VOTE_TOTAL, {8'($urandom), 8'(pick_span(1, 8))});
    if ($urandom_range(0, 1))
      write_reg(CFG_VOTE_MIN, {8'($urandom), 8'(pick_span(0, 6))});
  endtask

  initial begin
    bit busy;
    rst       = 1'b1;
    in_valid  = 1'b0;
    echo_us   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    busy      = 1'b0;
    model_cfg = '{RST_MODE, RST_TIMEOUT, RST_MIN_DIST, RST_MAX_DIST, RST_SAMPLE_CNT,
                  RST_WALL_THR, RST_VOTE_TOTAL, RST_VOTE_MIN};
    {run_sum, run_hits, run_seen, run_near} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        if (busy)
          settle();
        busy = 1'b0;
        write_reg(DIRECTED[r].idx, DIRECTED[r].val);
      end else begin
        send_echo(DIRECTED[r].val, DIRECTED[r].chk, DIRECTED[r].want);
        busy = 1'b1;
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      tx_gaps   = ph < RAND_PHASES - CALM_PHASES && $urandom_range(0, 3) != 0;
      rx_stalls = ph < RAND_PHASES - CALM_PHASES && $urandom_range(0, 3) != 0;
      if (ph == PRESSURE_PHASE) begin
        // One result per item, so a long output hold backs up into the input.
        write_reg(CFG_MODE, 16'(MODE_AVERAGE));
        write_reg(CFG_SAMPLE_CNT, 16'd1);
        tx_gaps = 1'b0;
        hold_asks++;
      end else begin
        reshuffle_regs();
      end
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_echo(pick_echo(), 1'b0, '0);
    end
    settle();

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item: distance %0d valid %0b wall %0b detections %0d",
                 $time, distance, distance_valid, wall_ahead, detections);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (distance !== want.distance) begin
          $display("%0t: distance expected %0d got %0d", $time, want.distance, distance);
          mismatches++;
        end
        if (distance_valid !== want.distance_valid) begin
          $display("%0t: distance_valid expected %0b got %0b",
                   $time, want.distance_valid, distance_valid);
          mismatches++;
        end
        if (wall_ahead !== want.wall_ahead) begin
          $display("%0t: wall_ahead expected %0b got %0b", $time, want.wall_ahead, wall_ahead);
          mismatches++;
        end
        if (detections !== want.detections) begin
          $display("%0t: detections expected %0d got %0d",
                   $time, want.detections, detections);
          mismatches++;
        end
      end
    end
  end

  // Counts cycles in which no handshake of any channel completes.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STUCK_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

endmodule

[echo_distance_average_and_vote.f]
rtl/edav_pkg.sv
rtl/edav_alu.sv
rtl/edav_ctrl.sv
rtl/echo_distance_average_and_vote.sv
tb/sv/tb.sv
